// ----- hdl/tsd_pkg.sv -----
// tsd_pkg: shared types and constants of the token stream deframer
// used by tsd_front, tsd_queue, tsd_back and token_stream_deframer
package tsd_pkg;

    // default depth of the queue between parser and result serializer
    localparam int QUEUE_DEPTH_DEF = 4;

    // result event codes
    localparam logic [1:0] EV_HEADER = 2'd0;
    localparam logic [1:0] EV_BYTE   = 2'd1;
    localparam logic [1:0] EV_END    = 2'd2;
    localparam logic [1:0] EV_DONE   = 2'd3;

    // buffer status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MAGIC    = 3'd1;
    localparam logic [2:0] ST_TRUNC    = 3'd2;
    localparam logic [2:0] ST_TYPE     = 3'd3;
    localparam logic [2:0] ST_TRAILING = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_ATTR  = 2'd1;
    localparam logic [1:0] CFG_TEXT  = 2'd2;
    localparam logic [1:0] CFG_END   = 2'd3;

    // token kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_ATTR  = 2'd1;
    localparam logic [1:0] KIND_TEXT  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // all results caused by one input word
    typedef struct packed {
        logic        hdr;
        logic        sbyte;
        logic        tend;
        logic        done;
        logic [1:0]  kind;
        logic [31:0] depth;
        logic [1:0]  sel;
        logic [7:0]  data;
        logic [2:0]  status;
    } t_bundle;

    // magic sequence "PVTD1"
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h50;
            3'd1:    v = 8'h56;
            3'd2:    v = 8'h54;
            3'd3:    v = 8'h44;
            3'd4:    v = 8'h31;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/tsd_front.sv -----
// tsd_front: byte parser, holds the type code registers and the framing state
// depends on tsd_pkg; produces at most one result bundle per accepted word
module tsd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_take,
    input  logic [7:0]         i_data_byte,
    input  logic               i_final_byte,
    output logic               o_push,
    output tsd_pkg::t_bundle   o_bundle
);
    import tsd_pkg::*;

    // parser phases
    localparam logic [3:0] PH_MAGIC = 4'd0;
    localparam logic [3:0] PH_COUNT = 4'd1;
    localparam logic [3:0] PH_TYPE  = 4'd2;
    localparam logic [3:0] PH_DEPTH = 4'd3;
    localparam logic [3:0] PH_LEN0  = 4'd4;
    localparam logic [3:0] PH_STR0  = 4'd5;
    localparam logic [3:0] PH_LEN1  = 4'd6;
    localparam logic [3:0] PH_STR1  = 4'd7;
    localparam logic [3:0] PH_LEN2  = 4'd8;
    localparam logic [3:0] PH_STR2  = 4'd9;
    localparam logic [3:0] PH_TRAIL = 4'd10;
    localparam logic [3:0] PH_SINK  = 4'd11;

    logic [7:0]  r_code_start, r_code_attr, r_code_text, r_code_end;
    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_fbi, n_fbi;
    logic [31:0] r_ws, n_ws;
    logic [31:0] r_tokens, n_tokens;
    logic [31:0] r_sleft, n_sleft;
    logic [1:0]  r_kind, n_kind;
    logic [31:0] r_depth, n_depth;
    logic [2:0]  r_err, n_err;

    logic [31:0] ws_shift;
    logic [2:0]  fbi_inc;
    logic        take_done;
    logic [3:0]  ph_off;
    logic        fin_str;
    logic [1:0]  fin_sel;
    logic [31:0] sleft_dec;
    logic [31:0] tokens_dec;
    t_bundle     bnd;

    // type code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_start <= 8'd1;
            r_code_attr  <= 8'd2;
            r_code_text  <= 8'd3;
            r_code_end   <= 8'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START: r_code_start <= i_cfg_data;
                CFG_ATTR:  r_code_attr  <= i_cfg_data;
                CFG_TEXT:  r_code_text  <= i_cfg_data;
                CFG_END:   r_code_end   <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // little-endian word collection
    assign ws_shift   = {i_data_byte, r_ws[31:8]};
    assign fbi_inc    = r_fbi + 3'd1;
    assign take_done  = (fbi_inc >= 3'd4);
    assign ph_off     = r_phase - PH_LEN0;
    assign sleft_dec  = r_sleft - 32'd1;
    assign tokens_dec = r_tokens - 32'd1;

    // next state and results of one word
    always_comb begin
        n_phase  = r_phase;
        n_fbi    = r_fbi;
        n_ws     = r_ws;
        n_tokens = r_tokens;
        n_sleft  = r_sleft;
        n_kind   = r_kind;
        n_depth  = r_depth;
        n_err    = r_err;
        fin_str  = 1'b0;
        fin_sel  = 2'd0;
        bnd      = '0;

        case (r_phase)
            PH_MAGIC: begin
                if (r_fbi > 3'd4 || i_data_byte != magic_byte(r_fbi)) begin
                    n_err   = ST_MAGIC;
                    n_phase = PH_SINK;
                end else if (fbi_inc == 3'd5) begin
                    n_fbi   = 3'd0;
                    n_phase = PH_COUNT;
                end else begin
                    n_fbi = fbi_inc;
                end
            end
            PH_COUNT: begin
                n_ws  = ws_shift;
                n_fbi = take_done ? 3'd0 : fbi_inc;
                if (take_done) begin
                    n_tokens = ws_shift;
                    n_phase  = (ws_shift != 32'd0) ? PH_TYPE : PH_TRAIL;
                end
            end
            PH_TYPE: begin
                if (i_data_byte == r_code_start) begin
                    n_kind = KIND_START;
                end else if (i_data_byte == r_code_attr) begin
                    n_kind = KIND_ATTR;
                end else if (i_data_byte == r_code_text) begin
                    n_kind = KIND_TEXT;
                end else if (i_data_byte == r_code_end) begin
                    n_kind = KIND_END;
                end else begin
                    n_kind = KIND_START;
                    n_err  = ST_TYPE;
                end
                n_fbi   = 3'd0;
                n_phase = PH_DEPTH;
            end
            PH_DEPTH: begin
                n_ws  = ws_shift;
                n_fbi = take_done ? 3'd0 : fbi_inc;
                if (take_done) begin
                    n_depth = ws_shift;
                    bnd.hdr = (r_err == ST_OK);
                    n_phase = PH_LEN0;
                end
            end
            PH_LEN0, PH_LEN1, PH_LEN2: begin
                n_ws  = ws_shift;
                n_fbi = take_done ? 3'd0 : fbi_inc;
                if (take_done) begin
                    n_sleft = ws_shift;
                    if (ws_shift == 32'd0) begin
                        fin_str = 1'b1;
                        fin_sel = ph_off[2:1];
                    end else begin
                        n_phase = r_phase + 4'd1;
                    end
                end
            end
            PH_STR0, PH_STR1, PH_STR2: begin
                bnd.sbyte = (r_err == ST_OK);
                bnd.sel   = ph_off[2:1];
                bnd.data  = i_data_byte;
                n_sleft   = sleft_dec;
                if (sleft_dec == 32'd0) begin
                    fin_str = 1'b1;
                    fin_sel = ph_off[2:1];
                end
            end
            PH_TRAIL: begin
                n_err   = ST_TRAILING;
                n_phase = PH_SINK;
            end
            default: ;
        endcase

        // a string is complete: next string, token end, or the sink after an error
        if (fin_str) begin
            if (fin_sel == 2'd0) begin
                n_phase = PH_LEN1;
                n_fbi   = 3'd0;
            end else if (fin_sel == 2'd1) begin
                n_phase = PH_LEN2;
                n_fbi   = 3'd0;
            end else if (r_err != ST_OK) begin
                n_phase = PH_SINK;
            end else begin
                bnd.tend = 1'b1;
                n_tokens = tokens_dec;
                n_phase  = (tokens_dec != 32'd0) ? PH_TYPE : PH_TRAIL;
            end
        end

        bnd.kind  = n_kind;
        bnd.depth = n_depth;

        // final word: status and back to the start of a buffer
        if (i_final_byte) begin
            bnd.done = 1'b1;
            if (n_phase == PH_TRAIL) begin
                bnd.status = ST_OK;
            end else if (n_phase >= PH_SINK) begin
                bnd.status = n_err;
            end else begin
                bnd.status = ST_TRUNC;
            end
            n_phase  = PH_MAGIC;
            n_fbi    = 3'd0;
            n_ws     = 32'd0;
            n_tokens = 32'd0;
            n_sleft  = 32'd0;
            n_kind   = KIND_START;
            n_depth  = 32'd0;
            n_err    = ST_OK;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_fbi    <= 3'd0;
            r_ws     <= 32'd0;
            r_tokens <= 32'd0;
            r_sleft  <= 32'd0;
            r_kind   <= KIND_START;
            r_depth  <= 32'd0;
            r_err    <= ST_OK;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_fbi    <= n_fbi;
            r_ws     <= n_ws;
            r_tokens <= n_tokens;
            r_sleft  <= n_sleft;
            r_kind   <= n_kind;
            r_depth  <= n_depth;
            r_err    <= n_err;
        end
    end

    // only words that cause results enter the queue
    assign o_push   = i_take && (bnd.hdr || bnd.sbyte || bnd.tend || bnd.done);
    assign o_bundle = bnd;

endmodule

// ----- hdl/tsd_queue.sv -----
// tsd_queue: small first-in first-out queue of result bundles
// depends on tsd_pkg for the bundle type
module tsd_queue #(
    parameter int DEPTH = tsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tsd_pkg::t_bundle   i_wdata,
    input  logic               i_pop,
    output tsd_pkg::t_bundle   o_head,
    output logic               o_empty,
    output logic               o_full
);
    import tsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

endmodule

// ----- hdl/tsd_back.sv -----
// tsd_back: splits queued bundles into single results behind an output register
// depends on tsd_pkg for the bundle type and event codes
module tsd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsd_pkg::t_bundle   i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_event_res,
    output logic [1:0]         o_token_kind,
    output logic [31:0]        o_depth,
    output logic [1:0]         o_string_select,
    output logic [7:0]         o_payload,
    output logic [2:0]         o_status,
    output logic               o_run_last
);
    import tsd_pkg::*;

    logic [3:0]  r_used, n_used;
    logic        r_valid;
    logic [1:0]  r_ev, r_kind, r_sel;
    logic [31:0] r_depth;
    logic [7:0]  r_data;
    logic [2:0]  r_status;
    logic        r_last;

    logic [3:0]  pend;
    logic [3:0]  pick;
    logic        load;
    logic        emit;
    logic        last;
    logic [1:0]  ev;

    // events of the head bundle not yet sent, in result order
    assign pend = {i_head.done, i_head.tend, i_head.sbyte, i_head.hdr} & ~r_used;
    assign pick = pend & (~pend + 4'd1);
    assign load = !r_valid || !i_stall;
    assign emit = load && !i_empty;
    assign last = ((pend & ~pick) == 4'd0);
    assign o_pop = emit && last;

    // event code of the picked bit
    always_comb begin
        case (pick)
            4'b0001: ev = EV_HEADER;
            4'b0010: ev = EV_BYTE;
            4'b0100: ev = EV_END;
            default: ev = EV_DONE;
        endcase
    end

    always_comb begin
        n_used = r_used;
        if (emit) begin
            n_used = last ? 4'd0 : (r_used | pick);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_used <= n_used;
            if (load) begin
                r_valid <= !i_empty;
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ev     <= ev;
            r_kind   <= (ev == EV_DONE) ? 2'd0 : i_head.kind;
            r_depth  <= (ev == EV_DONE) ? 32'd0 : i_head.depth;
            r_sel    <= (ev == EV_BYTE) ? i_head.sel : 2'd0;
            r_data   <= (ev == EV_BYTE) ? i_head.data : 8'd0;
            r_status <= (ev == EV_DONE) ? i_head.status : ST_OK;
            r_last   <= last;
        end
    end

    assign o_valid         = r_valid;
    assign o_event_res     = r_ev;
    assign o_token_kind    = r_kind;
    assign o_depth         = r_depth;
    assign o_string_select = r_sel;
    assign o_payload       = r_data;
    assign o_status        = r_status;
    assign o_run_last      = r_last;

endmodule

// ----- hdl/token_stream_deframer.sv -----
// token_stream_deframer: one byte per cycle in, one result per cycle out, unless stalled.
// a taken byte's results pass through the bundle queue and then the output register.
// throughput: one byte per cycle while bytes cause at most one result each and the output
// is not stalled; a byte may cause up to three results, and the result serializer sends one
// per cycle, so a queue of QUEUE_DEPTH bundles absorbs bursts before input stall rises.
// reset (synchronous, active low) empties queue and output, clears the parser, codes 1 to 4.
module token_stream_deframer #(
    parameter int QUEUE_DEPTH = tsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_event_res,
    output logic [1:0]  o_token_kind,
    output logic [31:0] o_depth,
    output logic [1:0]  o_string_select,
    output logic [7:0]  o_payload,
    output logic [2:0]  o_status,
    output logic        o_run_last
);
    import tsd_pkg::*;

    logic    take;
    logic    push;
    logic    pop;
    logic    empty;
    logic    full;
    t_bundle wbnd;
    t_bundle head;

    // input word taken whenever the queue has room
    assign o_stall = full;
    assign take    = i_valid && !full;

    // parser
    tsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_take       (take),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_push       (push),
        .o_bundle     (wbnd)
    );

    // bundle queue
    tsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wbnd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    // result serializer
    tsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_res     (o_event_res),
        .o_token_kind    (o_token_kind),
        .o_depth         (o_depth),
        .o_string_select (o_string_select),
        .o_payload       (o_payload),
        .o_status        (o_status),
        .o_run_last      (o_run_last)
    );

endmodule
